// File: design/svpwm_pkg.sv
// Shared types and constants for the space-vector PWM duty calculation core.
// No dependencies; every other file in this folder imports this package.
package svpwm_pkg;

  localparam int IN_W       = 16;  // signed input voltage width
  localparam int DUTY_W     = 15;  // duty field width
  localparam int CODE_W     = 3;   // sector code width
  localparam int XW         = 34;  // projections at 2^16 times the input scale
  localparam int RND_SHIFT  = 16;  // scale-down shift of the projections
  localparam int U_W        = XW - RND_SHIFT;  // rounded projection width
  localparam int TIME_W     = 16;  // clamped active time width (below 2^16)
  localparam int SUM_W      = TIME_W + 1;
  localparam int REM_W      = SUM_W + 1;       // divider partial remainder

  // sqrt(3)/2 in Q16, held as a positive signed constant.
  localparam logic signed [17:0]   K_SQRT3_HALF = 18'sd56756;
  // Half an LSB at the projection scale, for round-half-up.
  localparam logic signed [XW-1:0] RND_HALF     = 34'sd32768;

  // Sector codes: bit 0 = u1 > 0, bit 1 = u2 > 0, bit 2 = u3 > 0.
  localparam logic [CODE_W-1:0] SEC_ZERO = 3'd0;
  localparam logic [CODE_W-1:0] SEC_U1   = 3'd1;
  localparam logic [CODE_W-1:0] SEC_U2   = 3'd2;
  localparam logic [CODE_W-1:0] SEC_U12  = 3'd3;
  localparam logic [CODE_W-1:0] SEC_U3   = 3'd4;
  localparam logic [CODE_W-1:0] SEC_U13  = 3'd5;
  localparam logic [CODE_W-1:0] SEC_U23  = 3'd6;
  localparam logic [CODE_W-1:0] SEC_ALL  = 3'd7;

  // Word that moves down the divider chain, one cell per cycle while the chain is enabled.
  typedef struct packed {
    logic [REM_W-1:0]  rx;      // partial remainder, first active time
    logic [REM_W-1:0]  ry;      // partial remainder, second active time
    logic [SUM_W-1:0]  dsum;    // divisor: sum of both active times
    logic [CODE_W-1:0] code;
    logic              scaled;
    logic [TIME_W-1:0] tx;      // unscaled active times
    logic [TIME_W-1:0] ty;
  } div_word_t;

  // Result word as it leaves the core.
  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [DUTY_W-1:0] duty_c;
    logic [CODE_W-1:0] sector_code;
    logic              was_scaled;
  } result_t;

endpackage

// File: design/svpwm_if.sv
// Valid/ready channel interfaces for the input vector and the duty result.
// Depends on svpwm_pkg for field widths.
interface svpwm_in_if import svpwm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] v_alpha;
  logic signed [IN_W-1:0] v_beta;
  modport source (output valid, output v_alpha, output v_beta, input ready);
  modport sink   (input valid, input v_alpha, input v_beta, output ready);
endinterface

interface svpwm_out_if import svpwm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_a;
  logic [DUTY_W-1:0] duty_b;
  logic [DUTY_W-1:0] duty_c;
  logic [CODE_W-1:0] sector_code;
  logic              was_scaled;
  modport source (output valid, output duty_a, output duty_b, output duty_c,
                  output sector_code, output was_scaled, input ready);
  modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                  input sector_code, input was_scaled, output ready);
endinterface

// File: design/svpwm_div_cell.sv
// One restoring-division cell: produces one quotient bit for both active times.
// Depends on svpwm_pkg for the chain word type.
module svpwm_div_cell import svpwm_pkg::*; #(
  parameter int QW = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          valid_i,
  input  div_word_t     word_i,
  input  logic [QW-1:0] q_x_i,
  input  logic [QW-1:0] q_y_i,
  output logic          valid_o,
  output div_word_t     word_o,
  output logic [QW-1:0] q_x_o,
  output logic [QW-1:0] q_y_o
);

  logic             valid_r;
  div_word_t        word_r, word_nxt;
  logic [QW-1:0]    q_x_r, q_x_nxt, q_y_r, q_y_nxt;
  logic [REM_W-1:0] dvs, rem_x, rem_y;
  logic             ge_x, ge_y;

  always_comb begin
    dvs   = REM_W'(word_i.dsum);
    ge_x  = word_i.rx >= dvs;
    ge_y  = word_i.ry >= dvs;
    rem_x = word_i.rx - (ge_x ? dvs : '0);
    rem_y = word_i.ry - (ge_y ? dvs : '0);
    word_nxt    = word_i;
    // The remainder stays below the divisor, so doubling it cannot overflow.
    word_nxt.rx = {rem_x[REM_W-2:0], 1'b0};
    word_nxt.ry = {rem_y[REM_W-2:0], 1'b0};
    q_x_nxt = {q_x_i[QW-2:0], ge_x};
    q_y_nxt = {q_y_i[QW-2:0], ge_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
      q_x_r  <= q_x_nxt;
      q_y_r  <= q_y_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;
  assign q_x_o   = q_x_r;
  assign q_y_o   = q_y_r;

endmodule

// File: design/svpwm_front.sv
// Front pipeline: projections, sector code, active times and overmodulation test.
// Three register stages; depends on svpwm_pkg.
module svpwm_front import svpwm_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   valid_i,
  input  logic signed [IN_W-1:0] v_alpha,
  input  logic signed [IN_W-1:0] v_beta,
  output logic                   valid_o,
  output div_word_t              word_o
);

  localparam int CMP_W = (FRAC_BITS + 1 > SUM_W) ? FRAC_BITS + 1 : SUM_W;
  localparam logic [CMP_W-1:0] PERIOD_C = CMP_W'(1) << FRAC_BITS;

  // Stage 1: alpha times sqrt(3)/2.
  logic                   s1_v_r;
  logic signed [XW-1:0]   ka_r, ka_nxt;
  logic signed [IN_W-1:0] beta_r;

  assign ka_nxt = v_alpha * K_SQRT3_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ka_r   <= ka_nxt;
      beta_r <= v_beta;
    end
  end

  // Stage 2: u2 and u3 at full precision, sector code, rounding.
  logic                    s2_v_r;
  logic signed [XW-1:0]    hb, x2, x3, x2r, x3r;
  logic signed [U_W-1:0]   u1_r, u1_nxt, u2_r, u2_nxt, u3_r, u3_nxt;
  logic [CODE_W-1:0]       code_r, code_nxt;

  always_comb begin
    hb  = {{(XW - IN_W - 15){beta_r[IN_W-1]}}, beta_r, 15'b0};
    x2  = -ka_r - hb;
    x3  = ka_r - hb;
    x2r = x2 + RND_HALF;
    x3r = x3 + RND_HALF;
    // The upper part-select of a two's complement value is its floor shift.
    u1_nxt   = U_W'(beta_r);
    u2_nxt   = x2r[XW-1:RND_SHIFT];
    u3_nxt   = x3r[XW-1:RND_SHIFT];
    code_nxt = {x3 > 0, x2 > 0, beta_r > 0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r   <= u1_nxt;
      u2_r   <= u2_nxt;
      u3_r   <= u3_nxt;
      code_r <= code_nxt;
    end
  end

  // Stage 3: pick the two adjacent active times, clamp, sum and compare.
  logic                    s3_v_r;
  div_word_t               word_r, word_nxt;
  logic signed [U_W-1:0]   tx_s, ty_s;
  logic [TIME_W-1:0]       tcx, tcy;
  logic [SUM_W-1:0]        sum;

  always_comb begin
    case (code_r)
      SEC_U13: begin tx_s = u3_r;  ty_s = u1_r;  end
      SEC_U1:  begin tx_s = -u3_r; ty_s = -u2_r; end
      SEC_U12: begin tx_s = u1_r;  ty_s = u2_r;  end
      SEC_U2:  begin tx_s = -u1_r; ty_s = -u3_r; end
      SEC_U23: begin tx_s = u2_r;  ty_s = u3_r;  end
      SEC_U3:  begin tx_s = -u2_r; ty_s = -u1_r; end
      default: begin tx_s = '0;    ty_s = '0;    end
    endcase
    tcx = tx_s[U_W-1] ? '0 : tx_s[TIME_W-1:0];
    tcy = ty_s[U_W-1] ? '0 : ty_s[TIME_W-1:0];
    sum = SUM_W'(tcx) + SUM_W'(tcy);
    word_nxt.rx     = REM_W'(tcx);
    word_nxt.ry     = REM_W'(tcy);
    word_nxt.dsum   = sum;
    word_nxt.code   = code_r;
    word_nxt.scaled = CMP_W'(sum) > PERIOD_C;
    word_nxt.tx     = tcx;
    word_nxt.ty     = tcy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = s3_v_r;
  assign word_o  = word_r;

endmodule

// File: design/svpwm_duty_calculation_core.sv
// Space-vector PWM duty calculation core, seven-segment scheme.
// The path from the accepted input word to the result word runs through three front
// stages, FRAC_BITS + 1 divider cells and the output register. Throughput: one word
// per cycle while the skid register is empty; the divider chain is fully pipelined,
// one quotient bit per cell. Reset (synchronous, active low) clears all valid bits;
// there is no clearing pass, so the core is ready right after reset.
module svpwm_duty_calculation_core import svpwm_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  svpwm_in_if.sink     in_ch,
  svpwm_out_if.source  out_ch
);

  // One divider cell per quotient bit; the scaled time can reach the full period.
  localparam int QW    = FRAC_BITS + 1;
  localparam int DEPTH = QW;
  localparam int T_W   = (FRAC_BITS + 1 > SUM_W) ? FRAC_BITS + 1 : SUM_W;
  localparam logic [T_W-1:0]    PERIOD_T  = T_W'(1) << FRAC_BITS;
  localparam logic [DUTY_W-1:0] HALF_DUTY = DUTY_W'(PERIOD_T >> 1);

  // The whole pipeline advances together. It only halts when the skid
  // register is occupied, so input ready never waits on the output side
  // combinationally.
  logic en;

  div_word_t     chain_w  [DEPTH+1];
  logic          chain_v  [DEPTH+1];
  logic [QW-1:0] chain_qx [DEPTH+1];
  logic [QW-1:0] chain_qy [DEPTH+1];

  svpwm_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_ch.valid),
    .v_alpha (in_ch.v_alpha),
    .v_beta  (in_ch.v_beta),
    .valid_o (chain_v[0]),
    .word_o  (chain_w[0])
  );

  assign chain_qx[0] = '0;
  assign chain_qy[0] = '0;

  // Divider chain: each cell computes one bit of tx*T/sum and ty*T/sum and
  // hands the doubled remainders to its neighbor.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    svpwm_div_cell #(
      .QW (QW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (chain_v[k]),
      .word_i  (chain_w[k]),
      .q_x_i   (chain_qx[k]),
      .q_y_i   (chain_qy[k]),
      .valid_o (chain_v[k+1]),
      .word_o  (chain_w[k+1]),
      .q_x_o   (chain_qx[k+1]),
      .q_y_o   (chain_qy[k+1])
    );
  end

  // Duty assembly. When no scaling was needed the unscaled times are used.
  // The zero vector (and the impossible all-positive code) arrives with both
  // times at zero, so every phase falls out as half a period.
  div_word_t        last_w;
  logic [T_W-1:0]   fx, fy, half, xyh, yh, da, db, dc;
  result_t          res_w;

  always_comb begin
    last_w = chain_w[DEPTH];
    fx   = last_w.scaled ? T_W'(chain_qx[DEPTH]) : T_W'(last_w.tx);
    fy   = last_w.scaled ? T_W'(chain_qy[DEPTH]) : T_W'(last_w.ty);
    half = (PERIOD_T - fx - fy) >> 1;
    xyh  = fx + fy + half;
    yh   = fy + half;
    case (last_w.code)
      SEC_U13: begin da = xyh;  db = yh;   dc = half; end
      SEC_U1:  begin da = yh;   db = xyh;  dc = half; end
      SEC_U12: begin da = half; db = xyh;  dc = yh;   end
      SEC_U2:  begin da = half; db = yh;   dc = xyh;  end
      SEC_U23: begin da = yh;   db = half; dc = xyh;  end
      default: begin da = xyh;  db = half; dc = yh;   end
    endcase
    res_w.duty_a      = DUTY_W'(da);
    res_w.duty_b      = DUTY_W'(db);
    res_w.duty_c      = DUTY_W'(dc);
    res_w.sector_code = last_w.code;
    res_w.was_scaled  = last_w.scaled;
  end

  // Output register plus one skid register. A word leaving the chain while
  // the output word is stalled parks in the skid register, which then holds
  // the pipeline until the output drains.
  logic    out_v_r, out_v_nxt, skid_v_r, skid_v_nxt, push;
  result_t out_d_r, out_d_nxt, skid_d_r, skid_d_nxt;

  assign en   = !skid_v_r;
  assign push = en && chain_v[DEPTH];

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
        out_d_nxt = res_w;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = res_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign in_ch.ready        = en;
  assign out_ch.valid       = out_v_r;
  assign out_ch.duty_a      = out_d_r.duty_a;
  assign out_ch.duty_b      = out_d_r.duty_b;
  assign out_ch.duty_c      = out_d_r.duty_c;
  assign out_ch.sector_code = out_d_r.sector_code;
  assign out_ch.was_scaled  = out_d_r.was_scaled;

  // The skid register is only ever filled behind a stalled output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid word held without an output word");

  // A zero vector always gives half duty on every phase and no scaling.
  a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.sector_code == SEC_ZERO) |->
      (out_ch.duty_a == HALF_DUTY && out_ch.duty_b == HALF_DUTY &&
       out_ch.duty_c == HALF_DUTY && !out_ch.was_scaled))
    else $error("zero vector result is not half duty");

  // Scaling only happens in a real sector.
  a_scaled_sector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.was_scaled) |->
      (out_ch.sector_code != SEC_ZERO && out_ch.sector_code != SEC_ALL))
    else $error("scaled flag set without an active sector");

endmodule
